// ----- sv/kss_pkg.sv -----
package kss_pkg;

  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 3;
  localparam int DEPTH_DEF = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TOP    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;   // shift entries one cell deeper, new word into cell 0
    logic pop;    // shift entries one cell toward cell 0
    logic clear;  // drop the match chain before a new walk
    logic step;   // advance the match chain by one cell
  } cell_ctl_t;

endpackage

// ----- sv/kss_cell.sv -----
module kss_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  kss_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]            count,
  input  logic [kss_pkg::KEY_W-1:0] srch_key,
  input  logic [kss_pkg::KEY_W-1:0] up_key,
  input  logic [kss_pkg::PAY_W-1:0] up_pay,
  input  logic [kss_pkg::KEY_W-1:0] dn_key,
  input  logic [kss_pkg::PAY_W-1:0] dn_pay,
  input  logic                     fnd_in,
  input  logic [kss_pkg::PAY_W-1:0] fpay_in,
  output logic [kss_pkg::KEY_W-1:0] ent_key,
  output logic [kss_pkg::PAY_W-1:0] ent_pay,
  output logic                     fnd,
  output logic [kss_pkg::PAY_W-1:0] fpay
);
  import kss_pkg::*;

  logic occupied;
  logic match;

  // cell IDX sits at depth IDX below the top, so it is live while IDX < count
  assign occupied = (CW'(IDX) < count);
  assign match    = occupied && (ent_key == srch_key);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent_key <= up_key;
      ent_pay <= up_pay;
    end else if (ctl.pop) begin
      ent_key <= dn_key;
      ent_pay <= dn_pay;
    end
  end

  // match chain: hit flag and payload ripple one cell per step
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      fnd <= 1'b0;
    end else if (ctl.step) begin
      if (!fnd_in && match) begin
        fnd  <= 1'b1;
        fpay <= ent_pay;
      end else begin
        fnd  <= fnd_in;
        fpay <= fpay_in;
      end
    end
  end

endmodule

// ----- sv/keyed_stack_with_search.sv -----
// keyed stack with key search
// input channel: in_valid / in_stall with func, key, payload; one word is
// accepted at a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with status, out_key, out_payload,
// count and is_empty; exactly one result word per input word, in order
// the stack is a row of DEPTH cells, top entry in cell 0; push and pop
// shift the whole row by one cell at once
// push and search send a match chain down the row, one cell per cycle,
// and their result word is loaded once the chain has passed the bottom
// cell; pop and top skip the walk and read cell 0
// one item is in work at a time; in_stall is high while it is in work,
// and the next word is taken while a finished result waits in the output
// register
// when out_stall holds the output register, a finished item waits and the
// stack is left unchanged until the result can be loaded
// reset empties the stack (count 0) and drops any pending result; entry
// contents are not cleared
module keyed_stack_with_search #(
  parameter int DEPTH = kss_pkg::DEPTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kss_pkg::FUNC_W-1:0]  func,
  input  logic [kss_pkg::KEY_W-1:0]   key,
  input  logic [kss_pkg::PAY_W-1:0]   payload,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kss_pkg::STATUS_W-1:0] status,
  output logic [kss_pkg::KEY_W-1:0]   out_key,
  output logic [kss_pkg::PAY_W-1:0]   out_payload,
  output logic [CW-1:0]               count,
  output logic                        is_empty
);
  import kss_pkg::*;

  localparam int WCW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FIN
  } state_t;

  state_t              state;
  logic [FUNC_W-1:0]   op_func;
  logic [KEY_W-1:0]    op_key;
  logic [PAY_W-1:0]    op_pay;
  logic [WCW-1:0]      walk_cnt;
  logic [CW-1:0]       cnt;

  logic                accept;
  logic                fin_go;
  logic                found;
  logic [PAY_W-1:0]    found_pay;
  cell_ctl_t           ctl;

  logic [STATUS_W-1:0] res_status;
  logic [KEY_W-1:0]    res_key;
  logic [PAY_W-1:0]    res_pay;
  logic [CW-1:0]       cnt_next;
  logic                do_push;
  logic                do_pop;

  // cell row wiring
  logic [KEY_W-1:0] cell_key  [DEPTH];
  logic [PAY_W-1:0] cell_pay  [DEPTH];
  logic             chain_fnd [DEPTH];
  logic [PAY_W-1:0] chain_pay [DEPTH];

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign fin_go    = (state == S_FIN) && (!out_valid || !out_stall);
  assign found     = chain_fnd[DEPTH-1];
  assign found_pay = chain_pay[DEPTH-1];

  // result and new count of the item in work
  always_comb begin
    res_status = ST_OK;
    res_key    = '0;
    res_pay    = '0;
    cnt_next   = cnt;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    unique case (op_func)
      FN_PUSH: begin
        // duplicate wins over full
        if (found) begin
          res_status = ST_DUP;
        end else if (cnt >= CW'(DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          do_push  = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      FN_POP, FN_TOP: begin
        if (cnt == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_key = cell_key[0];
          res_pay = cell_pay[0];
          if (op_func == FN_POP) begin
            do_pop   = 1'b1;
            cnt_next = cnt - 1'b1;
          end
        end
      end
      FN_SEARCH: begin
        if (found) begin
          // keys are unique, so the single hit is also the one nearest the bottom
          res_key = op_key;
          res_pay = found_pay;
        end else begin
          res_status = ST_NOTFOUND;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  always_comb begin
    ctl.push  = fin_go && do_push;
    ctl.pop   = fin_go && do_pop;
    ctl.clear = accept;
    ctl.step  = (state == S_WALK);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] up_k;
    logic [PAY_W-1:0] up_p;
    logic [KEY_W-1:0] dn_k;
    logic [PAY_W-1:0] dn_p;
    logic             f_in;
    logic [PAY_W-1:0] fp_in;

    if (i == 0) begin : g_head
      assign up_k  = op_key;
      assign up_p  = op_pay;
      assign f_in  = 1'b0;
      assign fp_in = '0;
    end else begin : g_body
      assign up_k  = cell_key[i-1];
      assign up_p  = cell_pay[i-1];
      assign f_in  = chain_fnd[i-1];
      assign fp_in = chain_pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // bottom cell keeps its word on pop; it falls outside the count anyway
      assign dn_k = cell_key[i];
      assign dn_p = cell_pay[i];
    end else begin : g_inner
      assign dn_k = cell_key[i+1];
      assign dn_p = cell_pay[i+1];
    end

    kss_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (cnt),
      .srch_key (op_key),
      .up_key   (up_k),
      .up_pay   (up_p),
      .dn_key   (dn_k),
      .dn_pay   (dn_p),
      .fnd_in   (f_in),
      .fpay_in  (fp_in),
      .ent_key  (cell_key[i]),
      .ent_pay  (cell_pay[i]),
      .fnd      (chain_fnd[i]),
      .fpay     (chain_pay[i])
    );
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      walk_cnt  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // drained word leaves, unless a finished item reloads the register now
      if (out_valid && !out_stall && !fin_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_func  <= func;
            op_key   <= key;
            op_pay   <= payload;
            walk_cnt <= '0;
            // push and search need the full walk; pop and top read cell 0
            if (func == FN_PUSH || func == FN_SEARCH) begin
              state <= S_WALK;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_WALK: begin
          if (walk_cnt == WCW'(DEPTH - 1)) begin
            state <= S_FIN;
          end else begin
            walk_cnt <= walk_cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            out_key     <= res_key;
            out_payload <= res_pay;
            count       <= cnt_next;
            is_empty    <= (cnt_next == '0);
            cnt         <= cnt_next;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_cnt_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN) |=> $stable(cnt))
    else $error("entry count changed outside result load");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (is_empty && out_key == '0 && out_payload == '0))
    else $error("empty status with entry data or nonempty count");

  a_walk_full_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && walk_cnt != WCW'(DEPTH - 1)) |=> (state == S_WALK))
    else $error("match walk ended before reaching the bottom cell");
`endif

endmodule

// ----- dv/keyed_stack_with_search_tb.sv -----
module keyed_stack_with_search_tb;
  import kss_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CW    = $clog2(DEPTH + 1);
  // far above the slowest legal run: every word waits out gaps, stalls and the full walk
  localparam int LIMIT = 500000;

  // one result word as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [CW-1:0]       count;
    logic                is_empty;
  } stack_result_t;

  // mirror of the stack plus the results still owed by the block
  class stack_scoreboard;
    logic [KEY_W-1:0] keys [DEPTH];
    logic [PAY_W-1:0] payloads [DEPTH];
    int               depth_used;
    stack_result_t    awaited[$];
    int               errors;

    function new();
      depth_used = 0;
      errors     = 0;
    endfunction

    // lowest slot holding the key, -1 when absent
    function int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < depth_used; i++) begin
        if (keys[i] == k) return i;
      end
      return -1;
    endfunction

    // apply one accepted input word and queue the result it must produce
    function void note_word(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k,
                            logic [PAY_W-1:0] p);
      stack_result_t r;
      int            slot;
      r.status  = ST_OK;
      r.key     = '0;
      r.payload = '0;
      slot      = find_slot(k);
      case (fn)
        FN_PUSH: begin
          // duplicate test wins over full
          if (slot >= 0) r.status = ST_DUP;
          else if (depth_used == DEPTH) r.status = ST_FULL;
          else begin
            keys[depth_used]     = k;
            payloads[depth_used] = p;
            depth_used++;
          end
        end
        FN_POP, FN_TOP: begin
          if (depth_used == 0) r.status = ST_EMPTY;
          else begin
            r.key     = keys[depth_used-1];
            r.payload = payloads[depth_used-1];
            if (fn == FN_POP) depth_used--;
          end
        end
        default: begin
          if (slot < 0) r.status = ST_NOTFOUND;
          else begin
            r.key     = keys[slot];
            r.payload = payloads[slot];
          end
        end
      endcase
      r.count    = CW'(depth_used);
      r.is_empty = (depth_used == 0);
      awaited.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
                               logic [PAY_W-1:0] p, logic [CW-1:0] cnt, logic emp);
      stack_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result word with nothing expected: status %0d key %h payload %h",
                   st, k, p);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status || k !== want.key || p !== want.payload ||
          cnt !== want.count || emp !== want.is_empty) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected status %0d key %h payload %h count %0d empty %0d",
                   want.status, want.key, want.payload, want.count, want.is_empty);
          $display("          actual   status %0d key %h payload %h count %0d empty %0d",
                   st, k, p, cnt, emp);
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [FUNC_W-1:0]   func      = FN_PUSH;
  logic [KEY_W-1:0]    key       = '0;
  logic [PAY_W-1:0]    payload   = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    out_key;
  logic [PAY_W-1:0]    out_payload;
  logic [CW-1:0]       count;
  logic                is_empty;

  stack_scoreboard sb;
  int  send_idle  = 0;    // percent of cycles the sender leaves empty
  int  stall_pct  = 0;    // percent of cycles the receiver stalls
  logic hold_off  = 1'b0; // long receiver hold for the back-pressure phase
  bit  filling    = 1'b1; // random traffic leans toward push while set
  int  cycle_count = 0;
  int  drain_wait  = 0;
  int  idle_plan [4] = '{0, 56, 0, 27};
  int  stall_plan[4] = '{0, 0, 56, 27};

  keyed_stack_with_search u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key         (key),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_key     (out_key),
    .out_payload (out_payload),
    .count       (count),
    .is_empty    (is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("keyed_stack_with_search_tb: errors");
      $finish;
    end
  end

  // receiver: random stalls, forced high during the long hold
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  // out_stall is driven nonblocking, so this sees the value the block used
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, out_key, out_payload, count, is_empty);
  end

  // offer one word, with random gaps ahead of it, and wait until taken;
  // in_valid stays high into the next call so back-to-back words need no toggle
  task automatic send_word(logic [FUNC_W-1:0] fn, logic [KEY_W-1:0] k,
                           logic [PAY_W-1:0] p);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    func     <= fn;
    key      <= k;
    payload  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(fn, k, p);
  endtask

  // hold the receiver off long enough for the block to back up its input
  task automatic hold_receiver(int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // half the time a key already stored (duplicates, search hits), some from a tiny
  // range so misses turn into hits later, the rest fully random for bit coverage
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (sb.depth_used > 0 && r < 5) return sb.keys[$urandom_range(0, sb.depth_used - 1)];
    if (r < 7) return KEY_W'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // traffic swings between filling to full and draining to empty so both
  // boundaries, and pushes against a full stack, come up again and again
  task automatic send_random();
    int                r;
    logic [FUNC_W-1:0] fn;
    if (filling && sb.depth_used == DEPTH && $urandom_range(0, 4) == 0) filling = 1'b0;
    if (!filling && sb.depth_used == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    r = $urandom_range(0, 99);
    if (filling) fn = (r < 60) ? FN_PUSH : (r < 70) ? FN_POP : (r < 80) ? FN_TOP : FN_SEARCH;
    else         fn = (r < 15) ? FN_PUSH : (r < 65) ? FN_POP : (r < 80) ? FN_TOP : FN_SEARCH;
    send_word(fn, pick_key(), $urandom);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-stack corners, extreme keys and payloads, duplicate,
    // search hit and miss, top then pops back down to empty
    send_word(FN_POP,    '0, '0);
    send_word(FN_TOP,    '0, '0);
    send_word(FN_SEARCH, '0, '0);
    send_word(FN_PUSH,   '0, '0);
    send_word(FN_PUSH,   '1, '1);
    send_word(FN_PUSH,   '0, 32'h1234_5678);
    send_word(FN_SEARCH, '0, '0);
    send_word(FN_SEARCH, '1, '0);
    send_word(FN_SEARCH, 32'h0000_0005, '0);
    send_word(FN_TOP,    '0, '0);
    send_word(FN_POP,    '0, '0);
    send_word(FN_POP,    '0, '0);
    send_word(FN_POP,    '0, '0);
    send_word(FN_SEARCH, '1, '0);

    // back pressure: receiver frozen while the sender keeps offering words
    fork
      hold_receiver(200);
    join_none
    repeat (40) send_random();

    // random traffic under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_plan[ph];
      stall_pct = stall_plan[ph];
      repeat (375) send_random();
    end
    in_valid <= 1'b0;

    // let the last results drain, then let the clock run on before the verdict
    while (sb.pending() != 0 && drain_wait < 5000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("keyed_stack_with_search_tb: clean");
    else
      $display("keyed_stack_with_search_tb: errors");
    $finish;
  end

endmodule
